/* rtl/spectrum_band_peak_log_meter_assert.svh */
// assertion macros used by the meter's queue module
`ifndef SPECTRUM_BAND_PEAK_LOG_METER_ASSERT_SVH
`define SPECTRUM_BAND_PEAK_LOG_METER_ASSERT_SVH

// condition must never hold outside reset
`define SBPLM_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

// antecedent implies consequent in the same cycle
`define SBPLM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define SBPLM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sbplm_pkg.sv */
`default_nettype none

package sbplm_pkg;

  localparam int BAND_COUNT = 16;
  localparam int FRAME_BINS = 256;

  localparam logic [7:0] LAST_BIN         = 8'(FRAME_BINS - 1);
  localparam logic [3:0] LAST_BAND        = 4'(BAND_COUNT - 1);
  localparam logic [3:0] PEAK_SHIFT_RESET = 4'd7;
  localparam int         REG_PEAK_SHIFT   = 0;

  // last bin of each band, band 0 in the lowest byte
  localparam logic [15:0][7:0] BAND_END_BIN = {
    8'd254, 8'd186, 8'd136, 8'd100, 8'd73, 8'd53, 8'd39, 8'd27,
    8'd19,  8'd13,  8'd9,   8'd6,   8'd4,  8'd2,  8'd1,  8'd0
  };

  // one closed band waiting for its log
  typedef struct packed {
    logic [3:0] band;
    logic [7:0] level;
    logic       last;
  } sbplm_item_t;

  typedef logic [255:0][15:0] height_tbl_t;

  // square of a 2.62 fraction, truncated back to 62 fraction bits
  function automatic logic [63:0] fix_square(input logic [63:0] a);
    logic [63:0] a0;
    logic [63:0] a1;
    logic [63:0] p00;
    logic [63:0] p01;
    logic [63:0] p11;
    logic [63:0] mid;
    logic [63:0] lo;
    logic [63:0] hi;
    a0  = {32'd0, a[31:0]};
    a1  = {32'd0, a[63:32]};
    p00 = a0 * a0;
    p01 = a0 * a1;
    p11 = a1 * a1;
    mid = (p00 >> 32) + {32'd0, p01[31:0]} + {32'd0, p01[31:0]};
    lo  = {mid[31:0], p00[31:0]};
    hi  = p11 + (p01 >> 32) + (p01 >> 32) + (mid >> 32);
    return (hi << 2) | (lo >> 62);
  endfunction

  // floor(8192*log2(v)) for every 8-bit level, 0 for level 0
  function automatic height_tbl_t build_height_tbl();
    height_tbl_t tbl;
    logic [63:0] x;
    logic [12:0] frac;
    int          k;
    tbl = '0;
    for (int v = 1; v < 256; v++) begin
      k = 0;
      for (int j = 1; j < 8; j++) begin
        if ((v >> j) != 0) k = j;
      end
      x    = 64'(v) << (62 - k);
      frac = '0;
      for (int i = 0; i < 13; i++) begin
        x    = fix_square(x);
        frac = frac << 1;
        if (x[63]) begin
          frac[0] = 1'b1;
          x       = x >> 1;
        end
      end
      tbl[v] = {3'(k), frac};
    end
    return tbl;
  endfunction

  localparam height_tbl_t HEIGHT_TBL = build_height_tbl();

endpackage

`default_nettype wire

/* rtl/sbplm_front.sv */
`default_nettype none

module sbplm_front import sbplm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [3:0]  peak_shift,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] bin_value
  input  wire logic        in_tuser,   // [0] frame_start
  input  wire logic        q_full,
  output logic             q_push,
  output sbplm_item_t      q_item
);

  logic [7:0]  bin_count_r, bin_count_nxt;
  logic [3:0]  band_r, band_nxt;
  logic [14:0] peak_r, peak_nxt;

  logic        accept;
  logic [7:0]  cnt;
  logic [3:0]  band_cur;
  logic [14:0] peak_cur;
  logic [14:0] mag;
  logic [14:0] peak_upd;
  logic [14:0] shifted;
  logic        band_done;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    // frame start restarts count, band and peak before this beat is taken
    cnt      = in_tuser ? '0 : bin_count_r;
    band_cur = in_tuser ? '0 : band_r;
    peak_cur = in_tuser ? '0 : peak_r;

    mag       = in_tdata[15] ? '0 : in_tdata[14:0];
    peak_upd  = (mag > peak_cur) ? mag : peak_cur;
    band_done = (cnt != LAST_BIN) && (cnt == BAND_END_BIN[band_cur]);
    shifted   = peak_upd >> peak_shift;

    q_item.band  = band_cur;
    q_item.level = (|shifted[14:8]) ? 8'hff : shifted[7:0];
    q_item.last  = (band_cur == LAST_BAND);
    q_push       = accept && band_done;

    bin_count_nxt = bin_count_r;
    band_nxt      = band_r;
    peak_nxt      = peak_r;
    if (accept) begin
      bin_count_nxt = cnt + 8'd1;
      band_nxt      = band_cur;
      peak_nxt      = peak_cur;
      // the bin after the last band is skipped
      if (cnt != LAST_BIN) begin
        if (band_done) begin
          band_nxt = band_cur + 4'd1;
          peak_nxt = '0;
        end else begin
          peak_nxt = peak_upd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r <= '0;
      band_r      <= '0;
      peak_r      <= '0;
    end else begin
      bin_count_r <= bin_count_nxt;
      band_r      <= band_nxt;
      peak_r      <= peak_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/sbplm_queue.sv */
`default_nettype none
`include "spectrum_band_peak_log_meter_assert.svh"

module sbplm_queue import sbplm_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire sbplm_item_t push_item,
  output logic             full,
  input  wire logic        pop,
  output sbplm_item_t      pop_item,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sbplm_item_t      slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  `SBPLM_ASSERT_NEVER(a_push_full, clk, rst_n, push && full, "push into full queue")
  `SBPLM_ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && empty, "pop from empty queue")
  `SBPLM_ASSERT_NEVER(a_count_max, clk, rst_n, count_r > CNT_W'(DEPTH), "count overflow")
  `SBPLM_ASSERT_NEXT(a_push_only, clk, rst_n, push && !pop, count_r == $past(count_r) + 1'b1, "count not advanced")

endmodule

`default_nettype wire

/* rtl/sbplm_back.sv */
`default_nettype none

module sbplm_back import sbplm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_empty,
  input  wire sbplm_item_t q_item,
  output logic             q_pop,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [3:0] band, [19:4] height, [23:20] zero
  output logic             out_tlast   // band_last
);

  logic        out_valid_r, out_valid_nxt;
  logic [3:0]  band_r;
  logic [15:0] height_r;
  logic        last_r;

  // refill the output register from the queue whenever it is empty or being drained and the queue holds an item
  assign q_pop = !q_empty && (!out_valid_r || out_tready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      band_r   <= q_item.band;
      height_r <= HEIGHT_TBL[q_item.level];
      last_r   <= q_item.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, height_r, band_r};
  assign out_tlast  = last_r;

endmodule

`default_nettype wire

/* rtl/spectrum_band_peak_log_meter.sv */
`default_nettype none

// Band peak meter: takes one signed spectrum bin per beat (frame_start on
// in_tuser marks bin 0) and, on the last bin of each of 16 log-spaced bands,
// emits the band index and floor(8192*log2(v)) where v is the band's peak
// (negatives as zero) shifted right by peak_shift and capped at 255. One bin
// is accepted every cycle while the result queue is not full; a result goes
// through that queue into the output register. The front stage stalls only
// when the QUEUE_DEPTH-entry queue is full, i.e. after the result side has
// held off QUEUE_DEPTH + 1 results (one more waits in the output register).
// peak_shift lives at byte address 0 (reset 7).
// No clearing pass after reset: the block takes bins from the first cycle.
module spectrum_band_peak_log_meter import sbplm_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,    // [15:0] bin_value
  input  wire logic        in_tuser,    // [0] frame_start
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,   // [3:0] band, [19:4] height, [23:20] zero
  output logic             out_tlast,   // band_last
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [3:0]  peak_shift_r, peak_shift_nxt;
  logic        reg_sel;
  logic        q_full;
  logic        q_empty;
  logic        q_push;
  logic        q_pop;
  sbplm_item_t q_in_item;
  sbplm_item_t q_out_item;

  assign cfg_pready = 1'b1;
  assign reg_sel    = (cfg_paddr[2] == 1'(REG_PEAK_SHIFT));
  assign cfg_prdata = reg_sel ? {28'd0, peak_shift_r} : '0;

  always_comb begin
    peak_shift_nxt = peak_shift_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_sel) begin
      peak_shift_nxt = cfg_pwdata[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_shift_r <= PEAK_SHIFT_RESET;
    end else begin
      peak_shift_r <= peak_shift_nxt;
    end
  end

  sbplm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .peak_shift (peak_shift_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (q_in_item)
  );

  sbplm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_out_item),
    .empty     (q_empty)
  );

  sbplm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_item     (q_out_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
